FILE: rtl/core/cllw_pkg.sv
package cllw_pkg;

	localparam int DEF_COLUMNS = 16;
	localparam int QUEUE_DEPTH = 2;

	localparam logic [7:0] RESET_LINE_ONE_BASE = 8'h80;
	localparam logic [7:0] RESET_LINE_TWO_BASE = 8'hC0;
	localparam logic [7:0] LCD_CLEAR_DISPLAY   = 8'h01;
	localparam logic [7:0] CHAR_SPACE          = 8'h20;
	localparam logic [7:0] CHAR_QUESTION       = 8'h3F;

	localparam logic [15:0] CODE_TAB = 16'd9;
	localparam logic [15:0] CODE_LF  = 16'd10;
	localparam logic [15:0] CODE_FF  = 16'd12;
	localparam logic [15:0] CODE_CR  = 16'd13;

	// input command field
	localparam logic [1:0] CMD_PUT        = 2'd0;
	localparam logic [1:0] CMD_CLEAR_LINE = 2'd1;
	localparam logic [1:0] CMD_CLEAR_ALL  = 2'd2;

	// classified operations between front and back
	localparam logic [1:0] OP_PUT        = 2'd0;
	localparam logic [1:0] OP_CLEAR_LINE = 2'd1;
	localparam logic [1:0] OP_CLEAR_ALL  = 2'd2;
	localparam logic [1:0] OP_HOME       = 2'd3;

	localparam int CFG_INDEX_W = 1;
	localparam logic [CFG_INDEX_W-1:0] REG_LINE_ONE_BASE = 1'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_LINE_TWO_BASE = 1'd1;

	typedef struct packed {
		logic [1:0] op;
		logic       line;
		logic [7:0] mapped;
		logic [7:0] base;
	} item_t;

	typedef struct packed {
		logic       is_data;
		logic [7:0] bus_byte;
		logic       last;
	} res_t;

	// Cyrillic code page to controller character generator
	localparam logic [7:0] CODE_MAP [0:255] = '{
		8'o377, 8'o377, 8'o377, 8'o377, 8'o377, 8'o377, 8'o377, 8'o377,
		8'o377, 8'o377, 8'o377, 8'o377, 8'o377, 8'o377, 8'o377, 8'o377,
		8'o377, 8'o377, 8'o377, 8'o377, 8'o377, 8'o377, 8'o377, 8'o377,
		8'o377, 8'o377, 8'o377, 8'o377, 8'o377, 8'o377, 8'o377, 8'o377,
		8'o040, 8'o041, 8'o042, 8'o043, 8'o044, 8'o045, 8'o046, 8'o047,
		8'o050, 8'o051, 8'o052, 8'o053, 8'o054, 8'o055, 8'o056, 8'o057,
		8'o060, 8'o061, 8'o062, 8'o063, 8'o064, 8'o065, 8'o066, 8'o067,
		8'o070, 8'o071, 8'o072, 8'o073, 8'o074, 8'o075, 8'o076, 8'o077,
		8'o100, 8'o101, 8'o102, 8'o103, 8'o104, 8'o105, 8'o106, 8'o107,
		8'o110, 8'o111, 8'o112, 8'o113, 8'o114, 8'o115, 8'o116, 8'o117,
		8'o120, 8'o121, 8'o122, 8'o123, 8'o124, 8'o125, 8'o126, 8'o127,
		8'o130, 8'o131, 8'o132, 8'o133, 8'o004, 8'o135, 8'o136, 8'o137,
		8'o140, 8'o141, 8'o142, 8'o143, 8'o144, 8'o145, 8'o146, 8'o147,
		8'o150, 8'o151, 8'o152, 8'o153, 8'o154, 8'o155, 8'o156, 8'o157,
		8'o160, 8'o161, 8'o162, 8'o163, 8'o164, 8'o165, 8'o166, 8'o167,
		8'o170, 8'o171, 8'o172, 8'o005, 8'o321, 8'o006, 8'o351, 8'o377,
		8'o134, 8'o173, 8'o174, 8'o175, 8'o176, 8'o177, 8'o347, 8'o376,
		8'o310, 8'o311, 8'o312, 8'o313, 8'o314, 8'o315, 8'o316, 8'o317,
		8'o320, 8'o321, 8'o322, 8'o323, 8'o324, 8'o325, 8'o326, 8'o327,
		8'o330, 8'o331, 8'o332, 8'o333, 8'o334, 8'o335, 8'o336, 8'o337,
		8'o350, 8'o355, 8'o352, 8'o265, 8'o353, 8'o354, 8'o355, 8'o356,
		8'o357, 8'o360, 8'o361, 8'o362, 8'o363, 8'o364, 8'o365, 8'o366,
		8'o367, 8'o370, 8'o371, 8'o242, 8'o372, 8'o373, 8'o374, 8'o375,
		8'o377, 8'o377, 8'o377, 8'o377, 8'o377, 8'o377, 8'o377, 8'o377,
		8'o306, 8'o141, 8'o262, 8'o345, 8'o343, 8'o145, 8'o344, 8'o264,
		8'o170, 8'o270, 8'o271, 8'o272, 8'o273, 8'o274, 8'o275, 8'o157,
		8'o276, 8'o307, 8'o160, 8'o143, 8'o277, 8'o171, 8'o266, 8'o263,
		8'o304, 8'o303, 8'o267, 8'o301, 8'o305, 8'o346, 8'o300, 8'o302,
		8'o260, 8'o101, 8'o240, 8'o341, 8'o340, 8'o105, 8'o252, 8'o241,
		8'o130, 8'o245, 8'o246, 8'o113, 8'o247, 8'o115, 8'o110, 8'o117,
		8'o250, 8'o261, 8'o120, 8'o103, 8'o124, 8'o251, 8'o243, 8'o102,
		8'o007, 8'o256, 8'o244, 8'o254, 8'o257, 8'o342, 8'o253, 8'o255
	};

endpackage

FILE: rtl/core/cllw_queue.sv
module cllw_queue #(
	parameter int W     = 8,
	parameter int DEPTH = cllw_pkg::QUEUE_DEPTH
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] din,
	output logic         full,
	input  logic         pop,
	output logic [W-1:0] dout,
	output logic         empty
);
	import cllw_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [W-1:0]  entry_q [DEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_push, do_pop;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign dout    = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

FILE: rtl/core/cllw_front.sv
module cllw_front (
	input  logic                  push_ok,
	input  logic [1:0]            command,
	input  logic                  line_select,
	input  logic signed [15:0]    char_code,
	input  logic [7:0]            line_one_base,
	input  logic [7:0]            line_two_base,
	output logic                  enq,
	output cllw_pkg::item_t       item
);
	import cllw_pkg::*;

	logic       keep;
	logic [7:0] code_byte;

	always_comb begin
		keep        = 1'b0;
		item.op     = OP_PUT;
		item.line   = line_select;
		item.mapped = CODE_MAP[code_byte];
		item.base   = line_select ? line_two_base : line_one_base;
		unique case (command)
			CMD_PUT: begin
				keep = 1'b1;
				if (char_code == CODE_LF) begin
					keep = 1'b0;
				end else if (char_code == CODE_CR) begin
					item.op = OP_HOME;
				end else if (char_code == CODE_FF) begin
					item.op = OP_CLEAR_LINE;
				end
			end
			CMD_CLEAR_LINE: begin
				keep    = 1'b1;
				item.op = OP_CLEAR_LINE;
			end
			CMD_CLEAR_ALL: begin
				keep    = 1'b1;
				item.op = OP_CLEAR_ALL;
			end
			default: keep = 1'b0;
		endcase
	end

	// tab prints as space, anything outside one byte as question mark
	always_comb begin
		if (char_code == CODE_TAB) begin
			code_byte = CHAR_SPACE;
		end else if (char_code[15:8] != 8'h00) begin
			code_byte = CHAR_QUESTION;
		end else begin
			code_byte = char_code[7:0];
		end
	end

	assign enq = push_ok && keep;

endmodule

FILE: rtl/core/cllw_back.sv
module cllw_back #(
	parameter int COLUMNS = cllw_pkg::DEF_COLUMNS
) (
	input  logic            clk,
	input  logic            arst_n,
	input  cllw_pkg::item_t item,
	input  logic            item_empty,
	output logic            item_pop,
	input  logic            res_full,
	output logic            res_push,
	output cllw_pkg::res_t  res
);
	import cllw_pkg::*;

	localparam int CW    = $clog2(COLUMNS + 1);
	localparam int DEPTH = 2 * COLUMNS;
	localparam int AW    = $clog2(DEPTH);

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_CMD    = 3'd1;
	localparam logic [2:0] ST_SCROLL = 3'd2;
	localparam logic [2:0] ST_SPACE  = 3'd3;
	localparam logic [2:0] ST_DATA   = 3'd4;
	localparam logic [2:0] ST_FILL   = 3'd5;

	localparam logic [CW-1:0] COL_LAST = CW'(COLUMNS - 1);
	localparam logic [CW-1:0] COL_FULL = CW'(COLUMNS);

	function automatic logic [AW-1:0] addr_of(input logic ln, input logic [CW-1:0] c);
		return ln ? (AW'(COLUMNS) + AW'(c)) : AW'(c);
	endfunction

	logic [2:0]      state_q, next_q;
	logic [CW-1:0]   idx_q;
	logic [CW-1:0]   col_q [2];
	logic [DEPTH-1:0] valid_q;
	logic [7:0]      cmdbyte_q;
	logic            last_q;
	logic            line_q;
	logic [7:0]      mapped_q, base_q;

	logic [7:0]      mem [DEPTH];
	logic [7:0]      rdata_q;
	logic            rd_valid_q;
	logic [7:0]      rd_byte;

	logic            fire;
	logic            mem_we, mem_re;
	logic [AW-1:0]   waddr, raddr;
	logic [7:0]      wdata;
	logic [CW-1:0]   col_cur, col_item;

	assign fire     = (state_q != ST_IDLE) && !res_full;
	assign item_pop = (state_q == ST_IDLE) && !item_empty;
	assign res_push = fire;
	assign rd_byte  = rd_valid_q ? rdata_q : CHAR_SPACE;
	assign col_cur  = col_q[line_q];
	assign col_item = col_q[item.line];

	always_comb begin
		res.is_data  = 1'b1;
		res.bus_byte = CHAR_SPACE;
		res.last     = 1'b0;
		unique case (state_q)
			ST_IDLE: res.is_data = 1'b0;
			ST_CMD: begin
				res.is_data  = 1'b0;
				res.bus_byte = cmdbyte_q;
				res.last     = last_q;
			end
			ST_SCROLL: res.bus_byte = rd_byte;
			ST_SPACE:  res.bus_byte = CHAR_SPACE;
			ST_DATA: begin
				res.bus_byte = mapped_q;
				res.last     = 1'b1;
			end
			ST_FILL: res.last = (idx_q == COL_LAST);
			default: res.is_data = 1'b0;
		endcase
	end

	// scroll reads one column ahead while writing one column behind
	always_comb begin
		mem_re = 1'b0;
		raddr  = addr_of(item.line, CW'(1));
		mem_we = 1'b0;
		waddr  = addr_of(line_q, col_cur);
		wdata  = mapped_q;
		if (item_pop && item.op == OP_PUT && col_item >= COL_FULL) begin
			mem_re = 1'b1;
		end
		if (fire && state_q == ST_SCROLL) begin
			mem_we = 1'b1;
			waddr  = addr_of(line_q, idx_q - 1'b1);
			wdata  = rd_byte;
			mem_re = (idx_q != COL_LAST);
			raddr  = addr_of(line_q, idx_q + 1'b1);
		end else if (fire && state_q == ST_DATA) begin
			mem_we = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[waddr] <= wdata;
		end
		if (mem_re) begin
			rdata_q    <= mem[raddr];
			rd_valid_q <= valid_q[raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (item_pop) begin
			line_q   <= item.line;
			mapped_q <= item.mapped;
			base_q   <= item.base;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			next_q    <= ST_IDLE;
			idx_q     <= '0;
			col_q[0]  <= '0;
			col_q[1]  <= '0;
			valid_q   <= '0;
			cmdbyte_q <= '0;
			last_q    <= 1'b0;
		end else begin
			if (item_pop) begin
				unique case (item.op)
					OP_HOME: col_q[item.line] <= '0;
					OP_CLEAR_ALL: begin
						col_q[0]  <= '0;
						col_q[1]  <= '0;
						valid_q   <= '0;
						cmdbyte_q <= LCD_CLEAR_DISPLAY;
						last_q    <= 1'b1;
						next_q    <= ST_IDLE;
						state_q   <= ST_CMD;
					end
					OP_CLEAR_LINE: begin
						col_q[item.line] <= '0;
						for (int j = 0; j < DEPTH; j++) begin
							if ((j >= COLUMNS) == item.line) begin
								valid_q[j] <= 1'b0;
							end
						end
						cmdbyte_q <= item.base;
						last_q    <= 1'b0;
						idx_q     <= '0;
						next_q    <= ST_FILL;
						state_q   <= ST_CMD;
					end
					OP_PUT: begin
						last_q  <= 1'b0;
						state_q <= ST_CMD;
						if (col_item >= COL_FULL) begin
							cmdbyte_q <= item.base;
							idx_q     <= CW'(1);
							next_q    <= ST_SCROLL;
						end else begin
							cmdbyte_q <= item.base | 8'(col_item);
							next_q    <= ST_DATA;
						end
					end
					default: state_q <= ST_IDLE;
				endcase
			end else if (fire) begin
				unique case (state_q)
					ST_CMD: state_q <= next_q;
					ST_SCROLL: begin
						idx_q <= idx_q + 1'b1;
						if (idx_q == COL_LAST) begin
							state_q <= ST_SPACE;
						end
					end
					ST_SPACE: begin
						col_q[line_q] <= COL_LAST;
						cmdbyte_q     <= base_q | 8'(COL_LAST);
						last_q        <= 1'b0;
						next_q        <= ST_DATA;
						state_q       <= ST_CMD;
					end
					ST_DATA: begin
						col_q[line_q] <= col_cur + 1'b1;
						state_q       <= ST_IDLE;
					end
					ST_FILL: begin
						idx_q <= idx_q + 1'b1;
						if (idx_q == COL_LAST) begin
							state_q <= ST_IDLE;
						end
					end
					default: state_q <= ST_IDLE;
				endcase
			end
			if (mem_we) begin
				valid_q[waddr] <= 1'b1;
			end
		end
	end

	a_last_ends_item: assert property (@(posedge clk) disable iff (!arst_n)
		res_push && res.last |=> state_q == ST_IDLE)
		else $error("last transfer did not end the item");

	a_no_rw_clash: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we && mem_re |-> waddr != raddr)
		else $error("text read and write hit the same entry");

	a_col_range: assert property (@(posedge clk) disable iff (!arst_n)
		col_q[0] <= COL_FULL && col_q[1] <= COL_FULL)
		else $error("cursor column past line end");

	a_scroll_idx: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SCROLL |-> idx_q != '0 && idx_q <= COL_LAST)
		else $error("scroll index out of range");

endmodule

FILE: rtl/core/char_lcd_line_writer.sv
// An item's first controller write is registered in the back end, then in the result
// queue. Writes go one per cycle while the result queue has room; the scroll rate is
// set by the single read port of the line text memory. The back end takes a new item
// only when idle. A put on a full line scrolls it first, a line clear writes a space to
// every column, a screen clear sends one command, and a carriage return sends nothing.
// Reset (async, active low): both cursors at column 0, all text reads as spaces at once.
module char_lcd_line_writer #(
	parameter int COLUMNS = cllw_pkg::DEF_COLUMNS
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               push,
	output logic                               full,
	input  logic [1:0]                         command,
	input  logic                               line_select,
	input  logic signed [15:0]                 char_code,
	output logic                               empty,
	input  logic                               pop,
	output logic                               is_data,
	output logic [7:0]                         bus_byte,
	output logic                               last,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [cllw_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  logic [7:0]                         cfg_data
);
	import cllw_pkg::*;

	logic [7:0] line_one_base_q, line_two_base_q;
	logic       enq;
	item_t      front_item, back_item;
	logic       item_empty, item_pop;
	logic       res_full, res_push;
	res_t       back_res, out_res;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_one_base_q <= RESET_LINE_ONE_BASE;
			line_two_base_q <= RESET_LINE_TWO_BASE;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_LINE_ONE_BASE: line_one_base_q <= cfg_data;
				REG_LINE_TWO_BASE: line_two_base_q <= cfg_data;
				default: line_one_base_q <= line_one_base_q;
			endcase
		end
	end

	cllw_front u_front (
		.push_ok       (push && !full),
		.command       (command),
		.line_select   (line_select),
		.char_code     (char_code),
		.line_one_base (line_one_base_q),
		.line_two_base (line_two_base_q),
		.enq           (enq),
		.item          (front_item)
	);

	cllw_queue #(
		.W     ($bits(item_t)),
		.DEPTH (QUEUE_DEPTH)
	) u_item_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (enq),
		.din    (front_item),
		.full   (full),
		.pop    (item_pop),
		.dout   (back_item),
		.empty  (item_empty)
	);

	cllw_back #(
		.COLUMNS (COLUMNS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.item       (back_item),
		.item_empty (item_empty),
		.item_pop   (item_pop),
		.res_full   (res_full),
		.res_push   (res_push),
		.res        (back_res)
	);

	cllw_queue #(
		.W     ($bits(res_t)),
		.DEPTH (QUEUE_DEPTH)
	) u_res_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.din    (back_res),
		.full   (res_full),
		.pop    (pop),
		.dout   (out_res),
		.empty  (empty)
	);

	assign is_data  = out_res.is_data;
	assign bus_byte = out_res.bus_byte;
	assign last     = out_res.last;

endmodule
